// ===== design/kpeb_pkg.sv =====
// ---------------------------------------------------------------------------
// kpeb_pkg: shared types and constants of the keypad PIN entry buffer
// Key codes, beep codes, controller states and the keypad decode function.
// ---------------------------------------------------------------------------
package kpeb_pkg;

   typedef logic [4:0] key_code_type;
   typedef logic [1:0] beep_type;

   localparam key_code_type CODE_CLEAR = 5'd14;
   localparam key_code_type CODE_BACK  = 5'd15;
   localparam key_code_type CODE_ENTER = 5'd16;
   localparam key_code_type CODE_NONE  = 5'd31;
   localparam key_code_type CODE_DIGIT_MAX = 5'd9;

   localparam beep_type BEEP_NONE   = 2'd0;
   localparam beep_type BEEP_SHORT  = 2'd1;
   localparam beep_type BEEP_LONG   = 2'd2;
   localparam beep_type BEEP_DOUBLE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_COUNT = 3'b010,
      ST_DIGIT = 3'b100
   } ctrl_state_type;

   // Code of the key behind one matrix bit (bit = column*4 + row).
   function automatic key_code_type code_of_bit(input logic [3:0] bit_idx);
      key_code_type code;
      case (bit_idx)
         4'd0:    code = 5'd1;
         4'd1:    code = 5'd2;
         4'd2:    code = 5'd3;
         4'd3:    code = CODE_CLEAR;
         4'd4:    code = 5'd4;
         4'd5:    code = 5'd5;
         4'd6:    code = 5'd6;
         4'd7:    code = CODE_BACK;
         4'd8:    code = 5'd7;
         4'd9:    code = 5'd8;
         4'd10:   code = 5'd9;
         4'd11:   code = CODE_ENTER;
         4'd13:   code = 5'd0;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

   // Lowest set bit wins; an empty matrix gives the no-key code.
   function automatic key_code_type decode_keys(input logic [15:0] matrix);
      key_code_type code;
      code = CODE_NONE;
      for (int b = 15; b >= 0; b--) begin
         if (matrix[b]) begin
            code = code_of_bit(4'(b));
         end
      end
      return code;
   endfunction

endpackage

// ===== design/keypad_pin_entry_buffer_core.sv =====
// ---------------------------------------------------------------------------
// keypad_pin_entry_buffer_core: PIN entry buffer fed by 4x4 keypad snapshots
// Decodes each snapshot, edits a digit buffer held in a small RAM and emits
// beep codes and password reports.
// ---------------------------------------------------------------------------
// Each request transfer carries one key matrix snapshot. A snapshot that
// changes nothing yields no response; a digit, backspace or clear yields one
// response transfer, and enter yields MAX_DIGITS+2 report bytes (ID, digit
// count, zero-padded digit slots). A snapshot is taken when the response
// register is free; an enter then keeps the request side closed while the
// report streams out of the digit RAM at one byte per cycle, held by any
// response stall. The RAM has one write and one registered read port;
// slots at or above the digit count are masked to zero on readout, so the
// RAM needs no clearing.
// ---------------------------------------------------------------------------
module keypad_pin_entry_buffer_core #(
   parameter int MAX_DIGITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_key_matrix,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kpeb_pkg::beep_type rsp_beep,
   output logic        rsp_report_valid,
   output logic [7:0]  rsp_report_byte,
   output logic        rsp_report_last,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import kpeb_pkg::*;

   // Count width holds MAX_DIGITS itself; index width addresses the RAM.
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_DIGITS);
   localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_DIGITS - 1);

   // Digit RAM, one registered read port.
   logic [3:0] digit_mem [MAX_DIGITS];
   logic [3:0] rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic           wr_en;
   logic [IW-1:0] wr_addr;
   logic [3:0]    wr_data;

   ctrl_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   key_code_type   prev_code_ff, prev_code_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [7:0]     report_id_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   beep_type   rsp_beep_ff, rsp_beep_in;
   logic       rsp_rvalid_ff, rsp_rvalid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   key_code_type code;
   logic slot_free, take, act;
   logic do_clear, do_back, do_enter, do_digit;
   logic idx_held;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign take      = req_valid && req_ready;

   assign code     = decode_keys(req_key_matrix);
   assign act      = take && (code != prev_code_ff) && (code != CODE_NONE);
   assign do_clear = act && (code == CODE_CLEAR) && (count_ff != '0);
   assign do_back  = act && (code == CODE_BACK)  && (count_ff != '0);
   assign do_enter = act && (code == CODE_ENTER) && (count_ff != '0);
   assign do_digit = act && (code <= CODE_DIGIT_MAX) && (count_ff < MAX_COUNT);

   // Append writes the new digit at the current count.
   assign wr_en   = do_digit;
   assign wr_addr = count_ff[IW-1:0];
   assign wr_data = code[3:0];

   // Read one slot ahead whenever a digit byte leaves, else hold the address.
   always_comb begin
      rd_addr = idx_ff;
      if (state_ff == ST_DIGIT && slot_free) begin
         rd_addr = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= digit_mem[rd_addr];
   end

   // Slots at or beyond the count report as zero.
   assign idx_held = CW'(idx_ff) < count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      prev_code_in  = prev_code_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_beep_in   = rsp_beep_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      // Drop the response once taken; a new load below overrides this.
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               prev_code_in = code;
               if (do_digit) begin
                  count_in      = count_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_beep_in   = BEEP_SHORT;
                  rsp_rvalid_in = 1'b0;
                  rsp_byte_in   = '0;
                  rsp_last_in   = 1'b1;
               end else if (do_back) begin
                  count_in      = count_ff - 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_beep_in   = BEEP_LONG;
                  rsp_rvalid_in = 1'b0;
                  rsp_byte_in   = '0;
                  rsp_last_in   = 1'b1;
               end else if (do_clear) begin
                  count_in      = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_beep_in   = BEEP_DOUBLE;
                  rsp_rvalid_in = 1'b0;
                  rsp_byte_in   = '0;
                  rsp_last_in   = 1'b1;
               end else if (do_enter) begin
                  // Report starts with the ID byte.
                  rsp_valid_in  = 1'b1;
                  rsp_beep_in   = BEEP_LONG;
                  rsp_rvalid_in = 1'b1;
                  rsp_byte_in   = report_id_ff;
                  rsp_last_in   = 1'b0;
                  idx_in        = '0;
                  state_in      = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_beep_in   = BEEP_NONE;
               rsp_rvalid_in = 1'b1;
               rsp_byte_in   = 8'(count_ff);
               rsp_last_in   = 1'b0;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_beep_in   = BEEP_NONE;
               rsp_rvalid_in = 1'b1;
               rsp_byte_in   = idx_held ? {4'd0, rd_data_ff} : 8'd0;
               rsp_last_in   = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  // Report done: empty the buffer.
                  idx_in   = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         prev_code_ff  <= CODE_NONE;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         report_id_ff  <= 8'd3;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         prev_code_ff  <= prev_code_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            report_id_ff <= csr_wr_data;
         end
      end
   end

   // Response payload holds without reset.
   always_ff @(posedge clock) begin
      rsp_beep_ff   <= rsp_beep_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_beep         = rsp_beep_ff;
   assign rsp_report_valid = rsp_rvalid_ff;
   assign rsp_report_byte  = rsp_byte_ff;
   assign rsp_report_last  = rsp_last_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the keypad PIN entry buffer
// Drives keypad snapshots through the request channel, predicts every beep
// and report byte in a local model of the digit buffer, and checks each
// response transfer in order against that prediction.
// ---------------------------------------------------------------------------
module tb_top;
   import kpeb_pkg::*;

   localparam int MAX_DIGITS = 15;
   localparam int MAX_SHOWN  = 10;

   // Matrix bits of the command keys (bit = column*4 + row).
   localparam int BIT_CLEAR = 3;
   localparam int BIT_BACK  = 7;
   localparam int BIT_ENTER = 11;

   typedef struct packed {
      beep_type   beep;
      logic       report_valid;
      logic [7:0] report_byte;
      logic       report_last;
   } pin_rsp_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [15:0]       req_key_matrix;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   beep_type          rsp_beep;
   logic              rsp_report_valid;
   logic [7:0]        rsp_report_byte;
   logic              rsp_report_last;
   logic              csr_wr_en;
   logic [7:0]        csr_wr_data;

   // Local copy of the buffer state and the report ID register.
   logic [3:0]   pin_digits [MAX_DIGITS];
   int           pin_count;
   key_code_type last_code;
   logic [7:0]   report_id_model;

   // Response transfers still owed by the block, oldest first.
   pin_rsp_type  pending_rsp [$];
   pin_rsp_type  want;

   bit           steady_mode = 1'b0;
   int           items_sent = 0;
   int           results_checked = 0;
   int           reports_seen = 0;
   int           error_count = 0;

   keypad_pin_entry_buffer_core #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_matrix   (req_key_matrix),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_beep         (rsp_beep),
      .rsp_report_valid (rsp_report_valid),
      .rsp_report_byte  (rsp_report_byte),
      .rsp_report_last  (rsp_report_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Buffer model
   // -------------------------------------------------------------------------

   // Keypad layout: columns 0..2 carry digits 1-9 top to bottom, the bottom
   // row carries clear, backspace and enter, column 3 only has the zero key.
   function automatic key_code_type keypad_code(input int row, input int col);
      if (col == 3) begin
         return (row == 1) ? key_code_type'(0) : CODE_NONE;
      end
      if (row == 3) begin
         return key_code_type'(CODE_CLEAR + col);
      end
      return key_code_type'(col * 3 + row + 1);
   endfunction

   // Scan from bit 0 upward; the first pressed key wins.
   function automatic key_code_type snapshot_code(input logic [15:0] matrix);
      for (int b = 0; b < 16; b++) begin
         if (matrix[b]) begin
            return keypad_code(b % 4, b / 4);
         end
      end
      return CODE_NONE;
   endfunction

   function automatic void owe_rsp(input beep_type beep, input logic rv,
                                   input logic [7:0] byte_val, input logic last);
      pin_rsp_type r;
      r.beep         = beep;
      r.report_valid = rv;
      r.report_byte  = byte_val;
      r.report_last  = last;
      pending_rsp.push_back(r);
   endfunction

   function automatic void empty_pin_buffer();
      pin_count = 0;
      foreach (pin_digits[i]) pin_digits[i] = '0;
   endfunction

   function automatic void reset_pin_model();
      empty_pin_buffer();
      last_code       = CODE_NONE;
      report_id_model = 8'd3;
   endfunction

   // Advance the model by one accepted snapshot and queue what it owes.
   function automatic void apply_snapshot(input logic [15:0] matrix);
      key_code_type code;
      code = snapshot_code(matrix);
      if (code != last_code && code != CODE_NONE) begin
         if (code == CODE_CLEAR && pin_count > 0) begin
            empty_pin_buffer();
            owe_rsp(BEEP_DOUBLE, 1'b0, 8'd0, 1'b1);
         end else if (code == CODE_BACK && pin_count > 0) begin
            pin_count--;
            pin_digits[pin_count] = '0;
            owe_rsp(BEEP_LONG, 1'b0, 8'd0, 1'b1);
         end else if (code == CODE_ENTER && pin_count > 0) begin
            owe_rsp(BEEP_LONG, 1'b1, report_id_model, 1'b0);
            owe_rsp(BEEP_NONE, 1'b1, 8'(pin_count), 1'b0);
            for (int i = 0; i < MAX_DIGITS; i++) begin
               owe_rsp(BEEP_NONE, 1'b1, (i < pin_count) ? 8'(pin_digits[i]) : 8'd0,
                       (i == MAX_DIGITS - 1));
            end
            empty_pin_buffer();
         end else if (code <= CODE_DIGIT_MAX && pin_count < MAX_DIGITS) begin
            pin_digits[pin_count] = code[3:0];
            pin_count++;
            owe_rsp(BEEP_SHORT, 1'b0, 8'd0, 1'b1);
         end
      end
      last_code = code;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic int digit_bit(input int digit);
      if (digit == 0) begin
         return 13;
      end
      return ((digit - 1) / 3) * 4 + (digit - 1) % 3;
   endfunction

   // Press the key at one bit; half the time also press random keys above it,
   // which the scan must not see.
   function automatic logic [15:0] press_key(input int b);
      logic [31:0] above;
      above = 32'($urandom_range(0, 65535)) & (32'hFFFF << (b + 1));
      if ($urandom_range(1) == 0) begin
         above = '0;
      end
      return 16'(above) | (16'd1 << b);
   endfunction

   // Offer one snapshot and hold it until the transfer happens. Entered and
   // left just after a falling edge.
   task automatic send_snapshot(input logic [15:0] matrix);
      while (!steady_mode && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_key_matrix <= matrix;
      do @(posedge clock); while (!req_ready);
      apply_snapshot(matrix);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the request side until every owed response has come, then give
   // the block time to finish a snapshot that owed nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_report_id(input logic [7:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      report_id_model = value;
   endtask

   // One PIN entry: digits with releases in between, sometimes a backspace,
   // an invalid key or a missing release, then enter (now and then clear).
   task automatic send_pin_entry();
      int len;
      len = ($urandom_range(99) < 20) ? $urandom_range(15, 18) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
         send_snapshot(press_key(digit_bit($urandom_range(9))));
         case ($urandom_range(9))
            0: send_snapshot(press_key(BIT_BACK));
            1: send_snapshot(press_key(($urandom_range(1) == 0) ? 12 : 14 + $urandom_range(1)));
            2: ;  // no release: a repeated digit must be dropped
            default: send_snapshot(16'h0000);
         endcase
      end
      if ($urandom_range(19) == 0) begin
         send_snapshot(press_key(BIT_CLEAR));
      end else begin
         send_snapshot(press_key(BIT_ENTER));
      end
      send_snapshot(16'h0000);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Empty-buffer commands, every key, repeats, invalid keys, a full buffer,
   // backspace, enter and clear, all with the reset report ID.
   task automatic test_directed_keys();
      int all_digit_bits [10];
      int fill_bits [6];
      all_digit_bits = '{0, 1, 2, 4, 5, 6, 8, 9, 10, 13};
      fill_bits      = '{0, 1, 2, 4, 5, 6};
      send_snapshot(16'h0800);
      send_snapshot(16'h0008);
      send_snapshot(16'h0080);
      send_snapshot(16'h0000);
      foreach (all_digit_bits[i]) begin
         send_snapshot(16'd1 << all_digit_bits[i]);
      end
      send_snapshot(16'h2000);
      send_snapshot(16'h1000);
      send_snapshot(16'h4000);
      send_snapshot(16'h8000);
      foreach (fill_bits[i]) begin
         send_snapshot(16'd1 << fill_bits[i]);
      end
      send_snapshot(16'hF080);
      send_snapshot(16'hFFFF);
      send_snapshot(16'h0800);
      send_snapshot(16'h0002);
      send_snapshot(16'h0008);
   endtask

   task automatic test_pin_entries(input logic [7:0] id, input int count);
      int target;
      write_report_id(id);
      target = items_sent + count;
      while (items_sent < target) begin
         send_pin_entry();
         if ($urandom_range(9) == 0) begin
            wait_drained();
         end
      end
   endtask

   // No idling on either side for a long stretch.
   task automatic test_steady_burst(input int count);
      int target;
      steady_mode = 1'b1;
      target = items_sent + count;
      while (items_sent < target) send_pin_entry();
      steady_mode = 1'b0;
   endtask

   // Unstructured snapshots: any mix of keys, single keys and releases.
   task automatic test_noise(input int count);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(2))
            0: send_snapshot(16'($urandom_range(0, 65535)));
            1: send_snapshot(16'd1 << $urandom_range(15));
            default: send_snapshot(16'h0000);
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_ready <= steady_mode || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $display("%0t: unexpected response beep=%0d rv=%0b byte=%0h last=%0b",
                        $realtime, rsp_beep, rsp_report_valid, rsp_report_byte,
                        rsp_report_last);
            end
         end else begin
            want = pending_rsp.pop_front();
            results_checked++;
            if (want.report_valid && want.beep == BEEP_LONG) begin
               reports_seen++;
            end
            if (rsp_beep !== want.beep || rsp_report_valid !== want.report_valid ||
                rsp_report_byte !== want.report_byte ||
                rsp_report_last !== want.report_last) begin
               error_count++;
               if (error_count <= MAX_SHOWN) begin
                  $display("%0t: mismatch beep %0d/%0d rv %0b/%0b byte %0h/%0h last %0b/%0b",
                           $realtime, want.beep, rsp_beep, want.report_valid,
                           rsp_report_valid, want.report_byte, rsp_report_byte,
                           want.report_last, rsp_report_last);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_key_matrix = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      reset_pin_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_keys();
      test_pin_entries(8'h00, 100);
      test_pin_entries(8'hFF, 90);
      test_steady_burst(70);
      test_noise(60);
      test_pin_entries(8'($urandom_range(1, 254)), 50);
      wait_drained();

      $display("Sent %0d keypad snapshots; checked %0d response transfers, %0d reports.",
               items_sent, results_checked, reports_seen);
      $display("Report IDs 3, 0, 255 and a random one; full and empty buffers; stalls.");
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Drop the run if it hangs; a correct run needs a small share of this.
   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still owed.", pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
